### hw/rtl/p2lik_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and arctangent table builder for the
// two-link planar arm solver. No dependencies.
package p2lik_pkg;

  // Default parameter values
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int COORD_BITS_DEF    = 16;

  // Register field widths and reset values
  localparam int LEN_W = 15;
  localparam logic [LEN_W-1:0] UPPER_RESET = 15'd13107;
  localparam logic [LEN_W-1:0] LOWER_RESET = 15'd11796;

  // Configuration register codes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_reg_t;

  // Port widths
  localparam int IN_W  = 16;
  localparam int ANG_W = 16;
  localparam int EL_W  = 15;

  // Datapath widths fixed by the link length width
  localparam int LIM_W  = 2 * LEN_W + 1;   // 2*l0*l1
  localparam int N_W    = LIM_W + 1;       // N once known to be within +-lim
  localparam int A_W    = LIM_W + 3;       // 2*l0^2 + N
  localparam int D_W    = 2 * LIM_W;       // lim^2 - N^2
  localparam int ROOT_W = LIM_W;           // floor square root of D
  localparam int R_W    = ROOT_W + 1;      // rounded root
  localparam int REM_W  = ROOT_W + 3;      // square root remainder

  // CORDIC word and angle accumulator
  localparam int CW        = 64;
  localparam int NORM_TOP  = 60;
  localparam int ANG_FRAC  = 40;
  localparam int ACC_W     = 44;
  localparam int TABLE_MAX = 32;
  localparam int DEG_SCALE = 23040;
  localparam int SCALE_W   = 16;

  // Unsigned 64-bit quotient by shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) scaled by 2^62, alternating series
  function automatic logic [63:0] atan_recip(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] k;
    p   = udiv64(64'd1 << 62, m);
    sum = '0;
    k   = '0;
    for (int it = 0; it < 64; it++) begin
      if (p != 64'd0) begin
        term = udiv64(p, 2 * k + 64'd1);
        if (k[0] == 1'b0) sum = sum + term;
        else sum = sum - term;
        p = udiv64(p, m * m);
        k = k + 64'd1;
      end
    end
    return sum;
  endfunction

  // Table entry i: atan(2^-i) as a fraction of a half turn, 2^40 scale
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] quarter;
    logic [63:0] r;
    logic [63:0] q;
    quarter = atan_recip(64'd2) + atan_recip(64'd3);
    q       = '0;
    r       = '0;
    if (i == 0) begin
      q = 64'd1 << (ANG_FRAC - 2);
    end else begin
      r = atan_recip(64'd1 << i);
      for (int b = 0; b < ANG_FRAC - 1; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= quarter) begin
          r    = r - quarter;
          q[0] = 1'b1;
        end
      end
      q = (q + 64'd1) >> 1;
    end
    return q;
  endfunction

endpackage

### hw/rtl/p2lik_front.sv
`timescale 1ns / 1ps
// Front end: squares, N, reach check and the square root operand D.
// Uses p2lik_pkg. Six register stages.
module p2lik_front #(
  parameter int COORD_BITS = p2lik_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic signed [COORD_BITS-1:0]           in_x,
  input  logic signed [COORD_BITS-1:0]           in_y,
  input  logic [p2lik_pkg::LEN_W-1:0]            l0,
  input  logic [p2lik_pkg::LEN_W-1:0]            l1,
  output logic                                   out_vld,
  output logic                                   out_unreach,
  output logic signed [p2lik_pkg::N_W-1:0]       out_n,
  output logic signed [p2lik_pkg::A_W-1:0]       out_a,
  output logic [p2lik_pkg::D_W-1:0]              out_d,
  output logic signed [COORD_BITS-1:0]           out_x,
  output logic signed [COORD_BITS-1:0]           out_y
);

  localparam int CB  = COORD_BITS;
  localparam int SQW = 2 * p2lik_pkg::LEN_W;
  localparam int NW  = ((2 * CB + 1 > SQW + 1) ? 2 * CB + 1 : SQW + 1) + 2;
  localparam int LW  = p2lik_pkg::LIM_W;

  // Stage 1: capture coordinates
  logic                 s1_v;
  logic signed [CB-1:0] s1_x, s1_y;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= in_x;
      s1_y <= in_y;
    end
  end

  // Stage 2: squares and link product
  logic                   s2_v;
  logic signed [2*CB-1:0] s2_xx, s2_yy;
  logic [SQW-1:0]         s2_l00, s2_l11, s2_l01;
  logic signed [CB-1:0]   s2_x, s2_y;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_xx  <= s1_x * s1_x;
      s2_yy  <= s1_y * s1_y;
      s2_l00 <= l0 * l0;
      s2_l11 <= l1 * l1;
      s2_l01 <= l0 * l1;
      s2_x   <= s1_x;
      s2_y   <= s1_y;
    end
  end

  // Stage 3: N and the limit 2*l0*l1
  logic                 s3_v;
  logic signed [NW-1:0] s3_n;
  logic [LW-1:0]        s3_lim, s3_a2;
  logic signed [CB-1:0] s3_x, s3_y;
  logic signed [NW-1:0] n_next;

  assign n_next = NW'(s2_xx) + NW'(s2_yy)
                - NW'($signed({1'b0, s2_l00})) - NW'($signed({1'b0, s2_l11}));

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_n   <= n_next;
      s3_lim <= {s2_l01, 1'b0};
      s3_a2  <= {s2_l00, 1'b0};
      s3_x   <= s2_x;
      s3_y   <= s2_y;
    end
  end

  // Stage 4: reach check, narrow N, form A
  logic                                s4_v, s4_un;
  logic signed [p2lik_pkg::N_W-1:0]    s4_n;
  logic signed [p2lik_pkg::A_W-1:0]    s4_a;
  logic [LW-1:0]                       s4_lim;
  logic signed [CB-1:0]                s4_x, s4_y;
  logic signed [NW-1:0]                lim_s;
  logic signed [p2lik_pkg::N_W-1:0]    n_nar;

  assign lim_s = NW'($signed({1'b0, s3_lim}));
  assign n_nar = s3_n[p2lik_pkg::N_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_un  <= (s3_n > lim_s) || (s3_n < -lim_s);
      s4_n   <= n_nar;
      s4_a   <= p2lik_pkg::A_W'($signed({1'b0, s3_a2})) + p2lik_pkg::A_W'(n_nar);
      s4_lim <= s3_lim;
      s4_x   <= s3_x;
      s4_y   <= s3_y;
    end
  end

  // Stage 5: squares of N and of the limit
  logic                                  s5_v, s5_un;
  logic signed [2*p2lik_pkg::N_W-1:0]    s5_nn;
  logic [p2lik_pkg::D_W-1:0]             s5_ll;
  logic signed [p2lik_pkg::N_W-1:0]      s5_n;
  logic signed [p2lik_pkg::A_W-1:0]      s5_a;
  logic signed [CB-1:0]                  s5_x, s5_y;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_nn <= s4_n * s4_n;
      s5_ll <= s4_lim * s4_lim;
      s5_un <= s4_un;
      s5_n  <= s4_n;
      s5_a  <= s4_a;
      s5_x  <= s4_x;
      s5_y  <= s4_y;
    end
  end

  // Stage 6: D = lim^2 - N^2
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= s5_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_d       <= s5_ll - s5_nn[p2lik_pkg::D_W-1:0];
      out_unreach <= s5_un;
      out_n       <= s5_n;
      out_a       <= s5_a;
      out_x       <= s5_x;
      out_y       <= s5_y;
    end
  end

endmodule

### hw/rtl/p2lik_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root, one root bit per stage, rounded
// to nearest in a final stage. Uses p2lik_pkg.
module p2lik_sqrt #(
  parameter int TAG_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [p2lik_pkg::D_W-1:0]     in_d,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_vld,
  output logic [p2lik_pkg::R_W-1:0]     out_root,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int DW = p2lik_pkg::D_W;
  localparam int RW = p2lik_pkg::ROOT_W;
  localparam int MW = p2lik_pkg::REM_W;

  logic          v   [RW+1];
  logic [DW-1:0] dq  [RW+1];
  logic [MW-1:0] rem [RW+1];
  logic [RW-1:0] rt  [RW+1];
  logic [TAG_W-1:0] tg [RW+1];

  assign v[0]   = in_vld;
  assign dq[0]  = in_d;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign tg[0]  = in_tag;

  // One root bit per stage: bring down two operand bits, try to subtract
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [MW-1:0] cur, trial;
    logic          take;

    assign cur   = {rem[k][MW-3:0], dq[k][DW-1:DW-2]};
    assign trial = {1'b0, rt[k], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (en) v[k+1] <= v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dq[k+1]  <= dq[k] << 2;
        rem[k+1] <= take ? cur - trial : cur;
        rt[k+1]  <= {rt[k][RW-2:0], take};
        tg[k+1]  <= tg[k];
      end
    end
  end

  // Round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= v[RW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_root <= {1'b0, rt[RW]} + p2lik_pkg::R_W'(rem[RW] > MW'(rt[RW]));
      out_tag  <= tg[RW];
    end
  end

endmodule

### hw/rtl/p2lik_atan2.sv
`timescale 1ns / 1ps
// Pipelined atan2 in 1/128 degree: half-turn pre-rotation, power-of-two
// normalisation, vectoring CORDIC stages, scale and round. Uses p2lik_pkg.
module p2lik_atan2 #(
  parameter int STAGES = p2lik_pkg::CORDIC_STAGES_DEF,
  parameter int IN_W   = 33
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [IN_W-1:0]             in_y,
  input  logic signed [IN_W-1:0]             in_x,
  output logic                               out_vld,
  output logic signed [p2lik_pkg::ANG_W-1:0] out_angle
);

  localparam int CW = p2lik_pkg::CW;
  localparam int AW = p2lik_pkg::ACC_W;
  localparam int PW = AW + p2lik_pkg::SCALE_W;
  localparam logic signed [AW-1:0] HALF = AW'(64'd1 << p2lik_pkg::ANG_FRAC);

  // Pre-rotate by a half turn when x is negative
  logic                 p_v, p_zero;
  logic signed [CW-1:0] p_x, p_y;
  logic signed [AW-1:0] p_acc;
  logic signed [CW-1:0] ex, ey;

  assign ex = CW'(in_x);
  assign ey = CW'(in_y);

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (en) p_v <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_zero <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        p_x   <= -ex;
        p_y   <= -ey;
        p_acc <= (in_y >= 0) ? HALF : -HALF;
      end else begin
        p_x   <= ex;
        p_y   <= ey;
        p_acc <= '0;
      end
    end
  end

  // Larger magnitude
  logic                 m_v, m_zero;
  logic signed [CW-1:0] m_x, m_y;
  logic signed [AW-1:0] m_acc;
  logic [CW-1:0]        m_m;
  logic [CW-1:0]        abs_y;

  assign abs_y = (p_y < 0) ? CW'(-p_y) : CW'(p_y);

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= p_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_m    <= (CW'(p_x) > abs_y) ? CW'(p_x) : abs_y;
      m_x    <= p_x;
      m_y    <= p_y;
      m_acc  <= p_acc;
      m_zero <= p_zero;
    end
  end

  // Normalise in three stages of two conditional shifts each
  logic                 nv    [4];
  logic                 nz    [4];
  logic signed [CW-1:0] nx    [4];
  logic signed [CW-1:0] ny    [4];
  logic signed [AW-1:0] nacc  [4];
  logic [CW-1:0]        nm    [4];

  assign nv[0]   = m_v;
  assign nz[0]   = m_zero;
  assign nx[0]   = m_x;
  assign ny[0]   = m_y;
  assign nacc[0] = m_acc;
  assign nm[0]   = m_m;

  for (genvar j = 0; j < 3; j++) begin : g_norm
    localparam int K1 = 32 >> (2 * j);
    localparam int K2 = 16 >> (2 * j);
    logic                 s1;
    logic                 s2;
    logic [CW-1:0]        m1;
    logic signed [CW-1:0] x1, y1;

    assign s1 = (nm[j] >> (p2lik_pkg::NORM_TOP - K1)) == '0;
    assign m1 = s1 ? nm[j] << K1 : nm[j];
    assign x1 = s1 ? nx[j] <<< K1 : nx[j];
    assign y1 = s1 ? ny[j] <<< K1 : ny[j];
    assign s2 = (m1 >> (p2lik_pkg::NORM_TOP - K2)) == '0;

    always_ff @(posedge clk) begin
      if (rst) nv[j+1] <= 1'b0;
      else if (en) nv[j+1] <= nv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nm[j+1]   <= s2 ? m1 << K2 : m1;
        nx[j+1]   <= s2 ? x1 <<< K2 : x1;
        ny[j+1]   <= s2 ? y1 <<< K2 : y1;
        nacc[j+1] <= nacc[j];
        nz[j+1]   <= nz[j];
      end
    end
  end

  // Vectoring CORDIC: drive y towards zero
  logic                 cv   [STAGES+1];
  logic                 cz   [STAGES+1];
  logic signed [CW-1:0] cx   [STAGES+1];
  logic signed [CW-1:0] cy   [STAGES+1];
  logic signed [AW-1:0] cacc [STAGES+1];

  assign cv[0]   = nv[3];
  assign cz[0]   = nz[3];
  assign cx[0]   = nx[3];
  assign cy[0]   = ny[3];
  assign cacc[0] = nacc[3];

  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    localparam logic signed [AW-1:0] TAB = AW'(p2lik_pkg::atan_entry(i));
    logic signed [CW-1:0] xs, ys;

    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (en) cv[i+1] <= cv[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cz[i+1] <= cz[i];
        if (cy[i] > 0) begin
          cx[i+1]   <= cx[i] + ys;
          cy[i+1]   <= cy[i] - xs;
          cacc[i+1] <= cacc[i] + TAB;
        end else begin
          cx[i+1]   <= cx[i] - ys;
          cy[i+1]   <= cy[i] + xs;
          cacc[i+1] <= cacc[i] - TAB;
        end
      end
    end
  end

  // Scale to 1/128 degree
  logic                 k_v, k_zero;
  logic signed [PW-1:0] k_prod;

  always_ff @(posedge clk) begin
    if (rst) k_v <= 1'b0;
    else if (en) k_v <= cv[STAGES];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k_prod <= cacc[STAGES] * $signed(p2lik_pkg::SCALE_W'(p2lik_pkg::DEG_SCALE));
      k_zero <= cz[STAGES];
    end
  end

  // Round to nearest, clamp, force zero for the zero vector
  localparam logic signed [PW:0] RND  = (PW+1)'(64'd1 << (p2lik_pkg::ANG_FRAC - 1));
  localparam logic signed [PW:0] LIMP = (PW+1)'(p2lik_pkg::DEG_SCALE);
  logic signed [PW:0] rt, rs;

  assign rt = (PW+1)'(k_prod) + RND;
  assign rs = rt >>> p2lik_pkg::ANG_FRAC;

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= k_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (k_zero) out_angle <= '0;
      else if (rs > LIMP) out_angle <= p2lik_pkg::ANG_W'(LIMP);
      else if (rs < -LIMP) out_angle <= p2lik_pkg::ANG_W'(-LIMP);
      else out_angle <= rs[p2lik_pkg::ANG_W-1:0];
    end
  end

endmodule

### hw/rtl/planar_two_link_inverse_kinematics.sv
`timescale 1ns / 1ps
// Two-link planar arm inverse kinematics, top level.
// Uses p2lik_pkg, p2lik_front, p2lik_sqrt and p2lik_atan2.
//
// Input beats carry a target point (target_x, target_y); output beats carry
// shoulder_angle, elbow_angle and unreachable, one result per target, in
// order. Both channels move a beat on a clock edge where valid is high and
// stall is low. The user must write link lengths through cfg_we / cfg_index /
// cfg_data only while no beat is in flight; the block does not enforce this.
//
// The pipeline is six front-end stages, 32 square root stages (one root bit
// each plus rounding), two product stages and CORDIC_STAGES + 7 atan2
// stages, then the output register. One target is taken every cycle while
// the receiver does not stall a waiting result.
//
// Reset clears all valid bits and loads the default link lengths. When the
// receiver stalls a waiting result the whole pipeline holds and in_stall
// rises in the same cycle; nothing is dropped or repeated.
module planar_two_link_inverse_kinematics #(
  parameter int CORDIC_STAGES = p2lik_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = p2lik_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [p2lik_pkg::IN_W-1:0]     target_x,
  input  logic signed [p2lik_pkg::IN_W-1:0]     target_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [p2lik_pkg::ANG_W-1:0]    shoulder_angle,
  output logic [p2lik_pkg::EL_W-1:0]            elbow_angle,
  output logic                                  unreachable,
  input  logic                                  cfg_we,
  input  logic [p2lik_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [p2lik_pkg::LEN_W-1:0]           cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int TAG_W = 2 * CB + p2lik_pkg::N_W + p2lik_pkg::A_W + 1;
  localparam int PW    = p2lik_pkg::A_W + CB;
  localparam int SW    = PW + 1;
  localparam int EW    = p2lik_pkg::R_W + 1;
  localparam int ALAT  = CORDIC_STAGES + 7;

  // Pipeline advances unless a finished result is held back
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Link length registers
  logic [p2lik_pkg::LEN_W-1:0] upper_len, lower_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= p2lik_pkg::UPPER_RESET;
      lower_len <= p2lik_pkg::LOWER_RESET;
    end else if (cfg_we) begin
      unique case (p2lik_pkg::cfg_reg_t'(cfg_index))
        p2lik_pkg::REG_UPPER: upper_len <= cfg_data;
        p2lik_pkg::REG_LOWER: lower_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take the low COORD_BITS bits, sign extended; wider settings see the
  // 16-bit field as unsigned
  logic signed [CB-1:0] cx, cy;
  if (CB <= p2lik_pkg::IN_W) begin : g_narrow
    assign cx = target_x[CB-1:0];
    assign cy = target_y[CB-1:0];
  end else begin : g_wide
    assign cx = $signed(CB'({1'b0, target_x}));
    assign cy = $signed(CB'({1'b0, target_y}));
  end

  // Front end
  logic                             f_v, f_un;
  logic signed [p2lik_pkg::N_W-1:0] f_n;
  logic signed [p2lik_pkg::A_W-1:0] f_a;
  logic [p2lik_pkg::D_W-1:0]        f_d;
  logic signed [CB-1:0]             f_x, f_y;

  p2lik_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(in_valid && !in_stall), .in_x(cx), .in_y(cy),
    .l0(upper_len), .l1(lower_len),
    .out_vld(f_v), .out_unreach(f_un), .out_n(f_n), .out_a(f_a), .out_d(f_d),
    .out_x(f_x), .out_y(f_y)
  );

  // Square root, with the rest of the item riding alongside
  logic                        q_v;
  logic [p2lik_pkg::R_W-1:0]   q_r;
  logic [TAG_W-1:0]            q_tag;

  p2lik_sqrt #(.TAG_W(TAG_W)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(f_v), .in_d(f_d), .in_tag({f_un, f_n, f_a, f_x, f_y}),
    .out_vld(q_v), .out_root(q_r), .out_tag(q_tag)
  );

  logic signed [CB-1:0]             t_x, t_y;
  logic signed [p2lik_pkg::A_W-1:0] t_a;
  logic signed [p2lik_pkg::N_W-1:0] t_n;
  logic                             t_un;
  logic signed [EW-1:0]             t_r;

  assign t_y  = q_tag[CB-1:0];
  assign t_x  = q_tag[2*CB-1:CB];
  assign t_a  = q_tag[2*CB+p2lik_pkg::A_W-1:2*CB];
  assign t_n  = q_tag[2*CB+p2lik_pkg::A_W+p2lik_pkg::N_W-1:2*CB+p2lik_pkg::A_W];
  assign t_un = q_tag[TAG_W-1];
  assign t_r  = $signed({1'b0, q_r});

  // Products for the shoulder vector
  logic                             m_v, m_un;
  logic signed [PW-1:0]             m_rx, m_ay, m_ax, m_ry;
  logic signed [EW-1:0]             m_r;
  logic signed [p2lik_pkg::N_W-1:0] m_n;

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= q_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_rx <= t_r * t_x;
      m_ay <= t_a * t_y;
      m_ax <= t_a * t_x;
      m_ry <= t_r * t_y;
      m_r  <= t_r;
      m_n  <= t_n;
      m_un <= t_un;
    end
  end

  // Sums for the shoulder vector
  logic                 s_v, s_un;
  logic signed [SW-1:0] s_sy, s_sx;
  logic signed [EW-1:0] s_r, s_n;

  always_ff @(posedge clk) begin
    if (rst) s_v <= 1'b0;
    else if (en) s_v <= m_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s_sy <= SW'(m_ay) - SW'(m_rx);
      s_sx <= SW'(m_ax) + SW'(m_ry);
      s_r  <= m_r;
      s_n  <= EW'(m_n);
      s_un <= m_un;
    end
  end

  // Both arctangents in step
  logic                                 sh_v, el_v;
  logic signed [p2lik_pkg::ANG_W-1:0]   sh_ang, el_ang;

  p2lik_atan2 #(.STAGES(CORDIC_STAGES), .IN_W(SW)) u_atan_shoulder (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s_v), .in_y(s_sy), .in_x(s_sx),
    .out_vld(sh_v), .out_angle(sh_ang)
  );

  p2lik_atan2 #(.STAGES(CORDIC_STAGES), .IN_W(EW)) u_atan_elbow (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s_v), .in_y(s_r), .in_x(s_n),
    .out_vld(el_v), .out_angle(el_ang)
  );

  // Delay the unreachable flag to match the arctangent latency
  logic un_line [ALAT+1];
  assign un_line[0] = s_un;
  for (genvar i = 0; i < ALAT; i++) begin : g_un
    always_ff @(posedge clk) begin
      if (en) un_line[i+1] <= un_line[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= sh_v && el_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      unreachable <= un_line[ALAT];
      if (un_line[ALAT]) begin
        shoulder_angle <= '0;
        elbow_angle    <= '0;
      end else begin
        shoulder_angle <= sh_ang;
        elbow_angle    <= (el_ang < 0) ? '0 : el_ang[p2lik_pkg::EL_W-1:0];
      end
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for planar_two_link_inverse_kinematics.
// Depends on p2lik_pkg and the solver RTL; predicts each joint-angle beat with its
// own integer model of the closed-form solution and CORDIC arctangent.
module testbench;

  typedef struct packed {
    logic signed [p2lik_pkg::ANG_W-1:0] shoulder;
    logic [p2lik_pkg::EL_W-1:0]         elbow;
    logic                               unreach;
  } joint_angles_t;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  logic signed [p2lik_pkg::IN_W-1:0]  target_x;
  logic signed [p2lik_pkg::IN_W-1:0]  target_y;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [p2lik_pkg::ANG_W-1:0] shoulder_angle;
  logic [p2lik_pkg::EL_W-1:0]         elbow_angle;
  logic                               unreachable;
  logic                               cfg_we;
  logic [p2lik_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [p2lik_pkg::LEN_W-1:0]        cfg_data;

  longint unsigned angle_step[p2lik_pkg::TABLE_MAX];
  longint          upper_len;
  longint          lower_len;
  joint_angles_t   pending_angles[$];
  int              errors;
  int              idle_cycles;
  int              burst_left;
  int              stall_mode;
  int              stall_count;

  planar_two_link_inverse_kinematics u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_x(target_x), .target_y(target_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .shoulder_angle(shoulder_angle), .elbow_angle(elbow_angle),
    .unreachable(unreachable),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // atan(1/m) in radians scaled by 2^62, alternating series
  function automatic longint unsigned atan_inv_q62(longint unsigned m);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned k;
    p   = (64'd1 << 62) / m;
    sum = 0;
    k   = 0;
    while (p != 0) begin
      if (k[0] == 1'b0) sum = sum + p / (2 * k + 1);
      else sum = sum - p / (2 * k + 1);
      p = p / (m * m);
      k++;
    end
    return sum;
  endfunction

  // Build the half-turn-scaled arctangent steps of the CORDIC
  task automatic build_angle_steps();
    longint unsigned quarter;
    longint unsigned rem;
    longint unsigned quo;
    quarter = atan_inv_q62(2) + atan_inv_q62(3);
    angle_step[0] = 64'd1 << (p2lik_pkg::ANG_FRAC - 2);
    for (int i = 1; i < p2lik_pkg::TABLE_MAX; i++) begin
      rem = atan_inv_q62(64'd1 << i);
      quo = 0;
      for (int b = 0; b < p2lik_pkg::ANG_FRAC - 1; b++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= quarter) begin
          rem = rem - quarter;
          quo[0] = 1'b1;
        end
      end
      angle_step[i] = (quo + 1) >> 1;
    end
  endtask

  // Square root rounded to nearest
  function automatic longint unsigned root_nearest(longint unsigned d);
    longint unsigned r;
    longint unsigned bitv;
    longint unsigned v;
    r    = 0;
    bitv = 64'd1 << 62;
    v    = d;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (d - r * r > r) r++;
    return r;
  endfunction

  // Vectoring CORDIC arctangent in 1/128 degree
  function automatic longint heading_deg128(longint yv, longint xv);
    longint          acc;
    longint          xs;
    longint          ys;
    longint          res;
    longint unsigned m;
    longint unsigned mx;
    longint unsigned my;
    int              sh;
    acc = 0;
    sh  = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      acc = (yv >= 0) ? (64'sd1 <<< p2lik_pkg::ANG_FRAC) : -(64'sd1 <<< p2lik_pkg::ANG_FRAC);
      xv  = -xv;
      yv  = -yv;
    end
    mx = (xv < 0) ? -xv : xv;
    my = (yv < 0) ? -yv : yv;
    m  = (mx > my) ? mx : my;
    while (m < (64'd1 << 59)) begin
      m = m << 1;
      sh++;
    end
    xv = xv <<< sh;
    yv = yv <<< sh;
    for (int i = 0; i < p2lik_pkg::CORDIC_STAGES_DEF; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv  = xv + ys;
        yv  = yv - xs;
        acc = acc + longint'(angle_step[i]);
      end else begin
        xv  = xv - ys;
        yv  = yv + xs;
        acc = acc - longint'(angle_step[i]);
      end
    end
    res = (acc * p2lik_pkg::DEG_SCALE + (64'sd1 <<< (p2lik_pkg::ANG_FRAC - 1)))
          >>> p2lik_pkg::ANG_FRAC;
    if (res > p2lik_pkg::DEG_SCALE) res = p2lik_pkg::DEG_SCALE;
    if (res < -p2lik_pkg::DEG_SCALE) res = -p2lik_pkg::DEG_SCALE;
    return res;
  endfunction

  // Closed-form joint angles for one target point
  function automatic joint_angles_t solve_joints(logic signed [p2lik_pkg::IN_W-1:0] tx,
                                                 logic signed [p2lik_pkg::IN_W-1:0] ty);
    joint_angles_t   ang;
    longint          x;
    longint          y;
    longint          n;
    longint          lim;
    longint          a;
    longint          r;
    longint          el;
    longint          sh;
    x   = tx;
    y   = ty;
    n   = x * x + y * y - upper_len * upper_len - lower_len * lower_len;
    lim = 2 * upper_len * lower_len;
    ang = '0;
    if (n > lim || n < -lim) begin
      ang.unreach = 1'b1;
      return ang;
    end
    r  = longint'(root_nearest(longint'(lim * lim - n * n)));
    a  = 2 * upper_len * upper_len + n;
    el = heading_deg128(r, n);
    if (el < 0) el = 0;
    sh = heading_deg128(-r * x + a * y, a * x + r * y);
    ang.shoulder = sh[p2lik_pkg::ANG_W-1:0];
    ang.elbow    = el[p2lik_pkg::EL_W-1:0];
    return ang;
  endfunction

  // Receiver stall pattern: modes picked at random among none, random, periodic, heavy
  always @(negedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= (stall_count % 7 < 3);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    joint_angles_t exp_ang;
    if (!rst && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result beat: shoulder %0d elbow %0d unreachable %0b",
               shoulder_angle, elbow_angle, unreachable);
        errors++;
      end else begin
        exp_ang = pending_angles.pop_front();
        if (shoulder_angle !== exp_ang.shoulder) begin
          $error("shoulder_angle expected %0d actual %0d", exp_ang.shoulder, shoulder_angle);
          errors++;
        end
        if (elbow_angle !== exp_ang.elbow) begin
          $error("elbow_angle expected %0d actual %0d", exp_ang.elbow, elbow_angle);
          errors++;
        end
        if (unreachable !== exp_ang.unreach) begin
          $error("unreachable expected %0b actual %0b", exp_ang.unreach, unreachable);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one target beat, with random gaps between bursts
  task automatic send_target(logic signed [p2lik_pkg::IN_W-1:0] tx,
                             logic signed [p2lik_pkg::IN_W-1:0] ty);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    target_x <= tx;
    target_y <= ty;
    do @(posedge clk); while (in_stall);
    pending_angles.push_back(solve_joints(tx, ty));
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected beat has arrived, then settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Present one register write for a cycle; the caller drops the enable
  task automatic write_link(p2lik_pkg::cfg_reg_t idx, logic [p2lik_pkg::LEN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    if (idx == p2lik_pkg::REG_UPPER) upper_len = val;
    else lower_len = val;
  endtask

  task automatic set_links(logic [p2lik_pkg::LEN_W-1:0] up,
                           logic [p2lik_pkg::LEN_W-1:0] low);
    wait_idle();
    write_link(p2lik_pkg::REG_UPPER, up);
    write_link(p2lik_pkg::REG_LOWER, low);
    cfg_we <= 1'b0;
  endtask

  // Mostly targets within +-reach on each axis, some anywhere in the coordinate range
  task automatic send_random_target();
    longint reach;
    longint x;
    longint y;
    reach = upper_len + lower_len;
    if (reach > 32767) reach = 32767;
    if ($urandom_range(0, 9) < 7) begin
      x = $signed($urandom_range(0, 32'(2 * reach))) - reach;
      y = $signed($urandom_range(0, 32'(2 * reach))) - reach;
    end else begin
      x = $signed($urandom_range(0, 65535)) - 32768;
      y = $signed($urandom_range(0, 65535)) - 32768;
    end
    send_target(x[p2lik_pkg::IN_W-1:0], y[p2lik_pkg::IN_W-1:0]);
  endtask

  // Extremes of the coordinates, axes and reach boundaries at reset lengths
  task automatic test_directed();
    send_target(16'sh8000, 16'sh8000);
    send_target(16'sh7fff, 16'sh7fff);
    send_target(16'sh8000, 16'sh7fff);
    send_target(16'sh7fff, 16'sh8000);
    send_target(16'sd0, 16'sd0);
    send_target(16'sd24903, 16'sd0);
    send_target(16'sd0, 16'sd24903);
    send_target(-16'sd24903, 16'sd0);
    send_target(16'sd0, -16'sd24903);
    send_target(16'sd1311, 16'sd0);
    send_target(16'sd1310, 16'sd0);
    send_target(16'sd24904, 16'sd0);
    send_target(-16'sd10000, 16'sd5000);
    send_target(-16'sd10000, -16'sd5000);
    send_target(16'sd12000, -16'sd9000);
    send_target(-16'sd1, 16'sd0);
    send_target(16'sd20000, 16'sd1);
  endtask

  // Equal links put the origin on the zero vector; also the length extremes
  task automatic test_link_extremes();
    set_links(15'd5000, 15'd5000);
    send_target(16'sd0, 16'sd0);
    send_target(16'sd10000, 16'sd0);
    send_target(-16'sd7071, 16'sd7071);
    set_links(15'd32767, 15'd32767);
    send_target(16'sh8000, 16'sh8000);
    send_target(16'sh7fff, 16'sd0);
    send_target(16'sd0, 16'sd0);
    set_links(15'd1, 15'd1);
    send_target(16'sd0, 16'sd0);
    send_target(16'sd1, 16'sd1);
    send_target(16'sd2, 16'sd0);
    set_links(15'd32767, 15'd1);
    send_target(16'sd32767, 16'sd0);
    send_target(16'sd0, -16'sd32766);
    send_target(16'sd100, 16'sd100);
  endtask

  // Random targets over several link settings, with an extra full drain mid-run
  task automatic test_random();
    logic [p2lik_pkg::LEN_W-1:0] ups[6];
    logic [p2lik_pkg::LEN_W-1:0] lows[6];
    ups  = '{15'd13107, 15'd32767, 15'd20000, 15'd1, 15'd4000, 15'd16383};
    lows = '{15'd11796, 15'd32767, 15'd6000, 15'd32767, 15'd4000, 15'd16384};
    for (int ph = 0; ph < 6; ph++) begin
      set_links(ups[ph], lows[ph]);
      for (int k = 0; k < 270; k++) begin
        if (ph == 0 && k == 135) wait_idle();
        send_random_target();
      end
    end
    set_links(p2lik_pkg::LEN_W'($urandom_range(1, 32767)),
              p2lik_pkg::LEN_W'($urandom_range(1, 32767)));
    for (int k = 0; k < 60; k++) send_random_target();
  endtask

  initial begin
    errors      = 0;
    burst_left  = 0;
    stall_mode  = 0;
    stall_count = 0;
    upper_len   = p2lik_pkg::UPPER_RESET;
    lower_len   = p2lik_pkg::LOWER_RESET;
    rst         = 1'b1;
    in_valid    = 1'b0;
    target_x    = '0;
    target_y    = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = p2lik_pkg::REG_UPPER;
    cfg_data    = '0;
    build_angle_steps();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_link_extremes();
    test_random();

    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
hw/rtl/p2lik_pkg.sv
hw/rtl/p2lik_front.sv
hw/rtl/p2lik_sqrt.sv
hw/rtl/p2lik_atan2.sv
hw/rtl/planar_two_link_inverse_kinematics.sv
test/testbench.sv
